// ----- design/ckt_pkg.sv -----
// ----------------------------------------------------------------------------
// Card key table package
// Shared types, codes and helpers for the card key table with presence toggle.
// ----------------------------------------------------------------------------
package ckt_pkg;

  localparam int unsigned CAPACITY_DEF = 64;
  localparam int unsigned KEY_BYTES    = 10;

  typedef enum logic [1:0] {
    REQ_LOAD   = 2'd0,
    REQ_DELETE = 2'd1,
    REQ_CHECK  = 2'd2,
    REQ_CLEAR  = 2'd3
  } req_e;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
  localparam logic [1:0] STAT_FULL      = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_MOVE,
    S_FINISH
  } state_e;

  typedef struct packed {
    logic [15:0] key_high;
    logic [63:0] key_low;
    logic [15:0] person;
    logic        present;
  } rec_t;

  typedef struct packed {
    logic shift;
    rec_t wb;
  } chain_ctrl_t;

  function automatic logic key_nonzero(input logic [15:0] hi, input logic [63:0] lo);
    logic [79:0] key;
    logic        ok;
    key = {hi, lo};
    ok  = 1'b1;
    for (int b = 0; b < KEY_BYTES; b++) begin
      if (key[8*b +: 8] == 8'd0) begin
        ok = 1'b0;
      end
    end
    return ok;
  endfunction

endpackage

// ----- design/ckt_if.sv -----
// ----------------------------------------------------------------------------
// Card key table channels
// Request and response channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface ckt_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [15:0] card_high;
  logic [63:0] card_low;
  logic [15:0] person_key;

  modport source (output valid, output req_type, output card_high, output card_low,
                  output person_key, input ready);
  modport sink (input valid, input req_type, input card_high, input card_low,
                input person_key, output ready);
endinterface

interface ckt_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] found_person;
  logic        now_inside;
  logic [5:0]  slot;
  logic [6:0]  entry_count;

  modport source (output valid, output status, output found_person, output now_inside,
                  output slot, output entry_count, input ready);
  modport sink (input valid, input status, input found_person, input now_inside,
                input slot, input entry_count, output ready);
endinterface

// ----- design/card_key_table_with_presence_toggle_unit.sv -----
// ----------------------------------------------------------------------------
// Card key table with presence toggle
// Keeps card records in a rotating chain of cells and serves load, delete,
// check and clear requests.
// ----------------------------------------------------------------------------
// Requests arrive on req_i and each one gives exactly one item on rsp_o.
// The records live in a ring of CAPACITY cells that rotates by one cell a
// cycle while a request is served, so every slot passes the head once per
// pass and the ring is back in place at the end of the pass.
// Load, check, clear and a delete that misses take one pass; the response
// item is registered in the finish step. A delete that hits takes a second
// pass to move the last record into the freed slot. One request is served
// at a time, so the block takes no new request until the last one has left
// its finish step. req_i.ready is high whenever the sequencer is idle, even
// while a response still waits; a finished request holds in its last step
// until the response register is free. Reset empties the table; the record
// cells keep their bits and are rewritten before they are read again.
// ----------------------------------------------------------------------------
module card_key_table_with_presence_toggle_unit #(
  parameter int unsigned CAPACITY = ckt_pkg::CAPACITY_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ckt_req_if.sink   req_i,
  ckt_rsp_if.source rsp_o
);

  ckt_pkg::rec_t        chain [CAPACITY];
  ckt_pkg::chain_ctrl_t ctrl;

  ckt_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_i),
    .rsp_o   (rsp_o),
    .head_i  (chain[0]),
    .chain_o (ctrl)
  );

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    if (g == CAPACITY - 1) begin : g_tail
      ckt_cell u_cell (
        .clk_i   (clk_i),
        .shift_i (ctrl.shift),
        .data_i  (ctrl.wb),
        .data_o  (chain[g])
      );
    end else begin : g_body
      ckt_cell u_cell (
        .clk_i   (clk_i),
        .shift_i (ctrl.shift),
        .data_i  (chain[g+1]),
        .data_o  (chain[g])
      );
    end
  end

endmodule

// ----- design/ckt_cell.sv -----
// ----------------------------------------------------------------------------
// Card key table cell
// Holds one record and passes it to its neighbor while the chain rotates.
// ----------------------------------------------------------------------------
module ckt_cell (
  input  logic         clk_i,
  input  logic         shift_i,
  input  ckt_pkg::rec_t data_i,
  output ckt_pkg::rec_t data_o
);

  ckt_pkg::rec_t rec_q;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      rec_q <= data_i;
    end
  end

  assign data_o = rec_q;

endmodule

// ----- design/ckt_ctrl.sv -----
// ----------------------------------------------------------------------------
// Card key table sequencer
// Rotates the cell chain once per pass and edits the record at the head.
// ----------------------------------------------------------------------------
module ckt_ctrl #(
  parameter int unsigned CAPACITY = ckt_pkg::CAPACITY_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  ckt_req_if.sink              req_i,
  ckt_rsp_if.source            rsp_o,
  input  ckt_pkg::rec_t        head_i,
  output ckt_pkg::chain_ctrl_t chain_o
);

  localparam int unsigned IDX_W = $clog2(CAPACITY);
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  ckt_pkg::state_e   state_q, state_d;
  logic [IDX_W-1:0]  k_q, k_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              hit_q;
  logic              rsp_valid_q;

  ckt_pkg::req_e     op_q;
  logic [15:0]       hi_q;
  logic [63:0]       lo_q;
  logic [15:0]       pid_q;
  logic              full_q;
  logic [IDX_W-1:0]  hit_idx_q;
  logic [15:0]       found_q;
  logic              inside_q;
  ckt_pkg::rec_t     last_q;

  logic [1:0]        status_q, status_d;
  logic [15:0]       rsp_found_q, rsp_found_d;
  logic              rsp_inside_q, rsp_inside_d;
  logic [5:0]        rsp_slot_q, rsp_slot_d;

  logic acc, rsp_free, scan_last, in_range, at_tail, is_last, pid_match, key_match, finish;

  assign acc       = req_i.valid && req_i.ready;
  assign rsp_free  = !rsp_valid_q || rsp_o.ready;
  assign scan_last = (k_q == IDX_W'(CAPACITY - 1));
  assign in_range  = (CNT_W'(k_q) < count_q);
  assign at_tail   = (CNT_W'(k_q) == count_q);
  assign is_last   = ((CNT_W'(k_q) + CNT_W'(1)) == count_q);
  assign pid_match = (state_q == ckt_pkg::S_SCAN) && (op_q == ckt_pkg::REQ_DELETE) &&
                     in_range && !hit_q && (head_i.person == pid_q);
  assign key_match = (state_q == ckt_pkg::S_SCAN) && (op_q == ckt_pkg::REQ_CHECK) &&
                     in_range && !hit_q && (head_i.key_high == hi_q) &&
                     (head_i.key_low == lo_q) &&
                     ckt_pkg::key_nonzero(head_i.key_high, head_i.key_low);
  assign finish    = (state_q == ckt_pkg::S_FINISH) && rsp_free;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ckt_pkg::S_IDLE: begin
        if (acc) state_d = ckt_pkg::S_SCAN;
      end
      ckt_pkg::S_SCAN: begin
        if (scan_last) begin
          if ((op_q == ckt_pkg::REQ_DELETE) && (hit_q || pid_match)) begin
            state_d = ckt_pkg::S_MOVE;
          end else begin
            state_d = ckt_pkg::S_FINISH;
          end
        end
      end
      ckt_pkg::S_MOVE: begin
        if (scan_last) state_d = ckt_pkg::S_FINISH;
      end
      ckt_pkg::S_FINISH: begin
        if (rsp_free) state_d = ckt_pkg::S_IDLE;
      end
      default: state_d = ckt_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    req_i.ready   = (state_q == ckt_pkg::S_IDLE);
    chain_o.shift = (state_q == ckt_pkg::S_SCAN) || (state_q == ckt_pkg::S_MOVE);
    chain_o.wb    = head_i;
    k_d           = k_q;
    if (chain_o.shift) begin
      k_d = scan_last ? '0 : k_q + IDX_W'(1);
    end
    if (state_q == ckt_pkg::S_SCAN) begin
      if ((op_q == ckt_pkg::REQ_LOAD) && !full_q && at_tail) begin
        chain_o.wb.key_high = hi_q;
        chain_o.wb.key_low  = lo_q;
        chain_o.wb.person   = pid_q;
        chain_o.wb.present  = 1'b0;
      end else if (key_match) begin
        chain_o.wb.present = !head_i.present;
      end
    end else if ((state_q == ckt_pkg::S_MOVE) && (k_q == hit_idx_q)) begin
      chain_o.wb = last_q;
    end
  end

  always_comb begin
    status_d     = ckt_pkg::STAT_OK;
    rsp_found_d  = '0;
    rsp_inside_d = 1'b0;
    rsp_slot_d   = '0;
    count_d      = count_q;
    unique case (op_q)
      ckt_pkg::REQ_LOAD: begin
        if (full_q) begin
          status_d = ckt_pkg::STAT_FULL;
        end else begin
          rsp_slot_d = 6'(count_q);
          count_d    = count_q + CNT_W'(1);
        end
      end
      ckt_pkg::REQ_DELETE: begin
        if (hit_q) begin
          rsp_slot_d = 6'(hit_idx_q);
          count_d    = count_q - CNT_W'(1);
        end else begin
          status_d = ckt_pkg::STAT_NOT_FOUND;
        end
      end
      ckt_pkg::REQ_CHECK: begin
        if (hit_q) begin
          rsp_slot_d   = 6'(hit_idx_q);
          rsp_found_d  = found_q;
          rsp_inside_d = inside_q;
        end else begin
          status_d = ckt_pkg::STAT_NOT_FOUND;
        end
      end
      ckt_pkg::REQ_CLEAR: begin
        count_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ckt_pkg::S_IDLE;
      k_q         <= '0;
      count_q     <= '0;
      hit_q       <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      if (acc) begin
        hit_q <= 1'b0;
      end else if (pid_match || key_match) begin
        hit_q <= 1'b1;
      end
      if (finish) begin
        count_q     <= count_d;
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      op_q   <= ckt_pkg::req_e'(req_i.req_type);
      hi_q   <= req_i.card_high;
      lo_q   <= req_i.card_low;
      pid_q  <= req_i.person_key;
      full_q <= (count_q >= CNT_W'(CAPACITY));
    end
    if (pid_match || key_match) begin
      hit_idx_q <= k_q;
      found_q   <= head_i.person;
      inside_q  <= !head_i.present;
    end
    if ((state_q == ckt_pkg::S_SCAN) && is_last) begin
      last_q <= head_i;
    end
    if (finish) begin
      status_q     <= status_d;
      rsp_found_q  <= rsp_found_d;
      rsp_inside_q <= rsp_inside_d;
      rsp_slot_q   <= rsp_slot_d;
    end
  end

  assign rsp_o.valid        = rsp_valid_q;
  assign rsp_o.status       = status_q;
  assign rsp_o.found_person = rsp_found_q;
  assign rsp_o.now_inside   = rsp_inside_q;
  assign rsp_o.slot         = rsp_slot_q;
  assign rsp_o.entry_count  = 7'(count_q);

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("Record count exceeds the table capacity.");

  a_move_on_hit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ckt_pkg::S_MOVE) |-> ((op_q == ckt_pkg::REQ_DELETE) && hit_q))
    else $error("Move pass entered without a delete hit.");

  a_idle_aligned : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ckt_pkg::S_IDLE) |-> (k_q == '0))
    else $error("Cell chain is not aligned while idle.");

  a_count_at_finish : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |-> ($past(state_q) == ckt_pkg::S_FINISH))
    else $error("Record count changed outside the finish step.");

  a_rsp_from_finish : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_q) |-> ($past(state_q) == ckt_pkg::S_FINISH))
    else $error("Response raised outside the finish step.");

endmodule

// ----- bench/ckt_checker.sv -----
// ----------------------------------------------------------------------------
// Card key table checker
// Watches the request and response channels of the card key table, keeps its
// own copy of the records, predicts the response to every accepted request
// and compares each accepted response with the oldest prediction.
// ----------------------------------------------------------------------------
module ckt_checker #(
  parameter int unsigned CAPACITY = ckt_pkg::CAPACITY_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ckt_req_if          req_i,
  ckt_rsp_if          rsp_i,
  output int unsigned fail_cnt_o,
  output int unsigned pending_o
);

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] person;
    logic        presence;
    logic [5:0]  slot;
    logic [6:0]  count;
  } card_rsp_t;

  logic [15:0] tbl_key_hi  [CAPACITY];
  logic [63:0] tbl_key_lo  [CAPACITY];
  logic [15:0] tbl_person  [CAPACITY];
  logic        tbl_inside  [CAPACITY];
  int unsigned tbl_count = 0;

  card_rsp_t   awaited_rsp_q [$];
  card_rsp_t   rsp_want;
  card_rsp_t   rsp_got;
  int unsigned mismatches = 0;

  function automatic bit card_key_usable(logic [15:0] hi, logic [63:0] lo);
    logic [79:0] full;
    bit          ok;
    full = {hi, lo};
    ok   = 1'b1;
    for (int n = 0; n < 80; n += 8) begin
      if (full[n +: 8] == 8'h00) begin
        ok = 1'b0;
      end
    end
    return ok;
  endfunction

  function automatic card_rsp_t serve_card_request(ckt_pkg::req_e kind, logic [15:0] hi,
                                                   logic [63:0] lo, logic [15:0] pid);
    card_rsp_t   r;
    int unsigned last;
    bit          hit;
    r        = '0;
    r.status = ckt_pkg::STAT_OK;
    hit      = 1'b0;
    case (kind)
      ckt_pkg::REQ_LOAD: begin
        if (tbl_count >= CAPACITY) begin
          r.status = ckt_pkg::STAT_FULL;
        end else begin
          tbl_key_hi[tbl_count] = hi;
          tbl_key_lo[tbl_count] = lo;
          tbl_person[tbl_count] = pid;
          tbl_inside[tbl_count] = 1'b0;
          r.slot    = tbl_count[5:0];
          tbl_count = tbl_count + 1;
        end
      end
      ckt_pkg::REQ_DELETE: begin
        r.status = ckt_pkg::STAT_NOT_FOUND;
        for (int unsigned i = 0; i < tbl_count && !hit; i++) begin
          if (tbl_person[i] == pid) begin
            last          = tbl_count - 1;
            tbl_key_hi[i] = tbl_key_hi[last];
            tbl_key_lo[i] = tbl_key_lo[last];
            tbl_person[i] = tbl_person[last];
            tbl_inside[i] = tbl_inside[last];
            tbl_count     = last;
            r.slot        = i[5:0];
            r.status      = ckt_pkg::STAT_OK;
            hit           = 1'b1;
          end
        end
      end
      ckt_pkg::REQ_CHECK: begin
        r.status = ckt_pkg::STAT_NOT_FOUND;
        for (int unsigned i = 0; i < tbl_count && !hit; i++) begin
          if (tbl_key_hi[i] == hi && tbl_key_lo[i] == lo &&
              card_key_usable(tbl_key_hi[i], tbl_key_lo[i])) begin
            tbl_inside[i] = ~tbl_inside[i];
            r.person      = tbl_person[i];
            r.presence    = tbl_inside[i];
            r.slot        = i[5:0];
            r.status      = ckt_pkg::STAT_OK;
            hit           = 1'b1;
          end
        end
      end
      default: begin
        tbl_count = 0;
      end
    endcase
    r.count = tbl_count[6:0];
    return r;
  endfunction

  task automatic compare_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (rsp_i.valid && rsp_i.ready) begin
        rsp_got = '{rsp_i.status, rsp_i.found_person, rsp_i.now_inside,
                    rsp_i.slot, rsp_i.entry_count};
        if (awaited_rsp_q.size() == 0) begin
          $display("%0t: response item with none expected, actual status %0h person %0h",
                   $time, rsp_got.status, rsp_got.person);
          mismatches++;
        end else begin
          rsp_want = awaited_rsp_q.pop_front();
          compare_field("status", rsp_want.status, rsp_got.status);
          compare_field("found_person", rsp_want.person, rsp_got.person);
          compare_field("now_inside", rsp_want.presence, rsp_got.presence);
          compare_field("slot", rsp_want.slot, rsp_got.slot);
          compare_field("entry_count", rsp_want.count, rsp_got.count);
        end
      end
      if (req_i.valid && req_i.ready) begin
        awaited_rsp_q.push_back(serve_card_request(ckt_pkg::req_e'(req_i.req_type),
                                                   req_i.card_high, req_i.card_low,
                                                   req_i.person_key));
      end
    end
    fail_cnt_o <= mismatches;
    pending_o  <= awaited_rsp_q.size();
  end

endmodule

// ----- bench/tb_top.sv -----
// ----------------------------------------------------------------------------
// Card key table testbench
// Drives directed and random load, delete, check and clear requests into the
// card key table under several idling and stalling phases, and gives the
// verdict from the failure and pending counts of the checker.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned CAP             = ckt_pkg::CAPACITY_DEF;
  localparam int unsigned ITEMS_PER_PHASE = 345;
  localparam int unsigned POOL_SIZE       = 48;
  localparam int unsigned CYCLE_LIMIT     = 1000000;

  logic        clk_i;
  logic        rst_ni;
  int unsigned fail_cnt;
  int unsigned pending;
  int unsigned cycles;
  int unsigned send_idle_pct;
  int unsigned stall_pct;
  int unsigned load_pct;

  logic [15:0] pool_hi [POOL_SIZE];
  logic [63:0] pool_lo [POOL_SIZE];

  ckt_req_if req_if ();
  ckt_rsp_if rsp_if ();

  card_key_table_with_presence_toggle_unit #(.CAPACITY(CAP)) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  ckt_checker #(.CAPACITY(CAP)) u_checker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req_if),
    .rsp_i     (rsp_if),
    .fail_cnt_o(fail_cnt),
    .pending_o (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever begin
      #5 clk_i = ~clk_i;
    end
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      rsp_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic make_card_key(input bit with_zero, output logic [15:0] hi,
                               output logic [63:0] lo);
    logic [79:0] k;
    int          b;
    for (int n = 0; n < 10; n++) begin
      k[8*n +: 8] = 8'($urandom_range(1, 255));
    end
    if (with_zero) begin
      b = $urandom_range(0, 9);
      k[8*b +: 8] = 8'h00;
    end
    {hi, lo} = k;
  endtask

  task automatic send_request(ckt_pkg::req_e kind, logic [15:0] hi, logic [63:0] lo,
                              logic [15:0] pid);
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid      <= 1'b1;
    req_if.req_type   <= kind;
    req_if.card_high  <= hi;
    req_if.card_low   <= lo;
    req_if.person_key <= pid;
    do begin
      @(posedge clk_i);
    end while (!req_if.ready);
  endtask

  task automatic drain_responses();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) begin
      @(posedge clk_i);
    end
  endtask

  task automatic random_request();
    logic [15:0] hi;
    logic [63:0] lo;
    logic [15:0] pid;
    int unsigned pick;
    int unsigned sel;
    pick = $urandom_range(POOL_SIZE - 1);
    hi   = pool_hi[pick];
    lo   = pool_lo[pick];
    sel  = $urandom_range(99);
    if (sel < 10) begin
      hi = 16'($urandom);
      lo = {$urandom, $urandom};
    end else if (sel < 20) begin
      make_card_key($urandom_range(3) == 0, hi, lo);
    end
    pid = ($urandom_range(99) < 70) ? 16'($urandom_range(0, 31)) : 16'($urandom);
    if ($urandom_range(99) < load_pct) begin
      send_request(ckt_pkg::REQ_LOAD, hi, lo, pid);
    end else begin
      sel = $urandom_range(99);
      if (sel < 3) begin
        send_request(ckt_pkg::REQ_CLEAR, hi, lo, pid);
      end else if (sel < 40) begin
        send_request(ckt_pkg::REQ_DELETE, hi, lo, pid);
      end else begin
        send_request(ckt_pkg::REQ_CHECK, hi, lo, pid);
      end
    end
  endtask

  initial begin
    rst_ni            = 1'b0;
    send_idle_pct     = 0;
    stall_pct         = 0;
    load_pct          = 50;
    req_if.valid      <= 1'b0;
    req_if.req_type   <= ckt_pkg::REQ_CLEAR;
    req_if.card_high  <= '0;
    req_if.card_low   <= '0;
    req_if.person_key <= '0;
    for (int i = 0; i < POOL_SIZE; i++) begin
      make_card_key(i % 6 == 5, pool_hi[i], pool_lo[i]);
    end
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_request(ckt_pkg::REQ_CLEAR, '0, '0, '0);
    send_request(ckt_pkg::REQ_CHECK, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF, '0);
    send_request(ckt_pkg::REQ_DELETE, '0, '0, 16'h0000);
    send_request(ckt_pkg::REQ_LOAD, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF);
    send_request(ckt_pkg::REQ_LOAD, 16'h00A5, 64'h1122_3344_5566_7788, 16'h0000);
    send_request(ckt_pkg::REQ_LOAD, 16'h0000, 64'h0, 16'h0001);
    send_request(ckt_pkg::REQ_LOAD, 16'h1A2B, 64'h3C4D_5E6F_7081_92A3, 16'h1234);
    send_request(ckt_pkg::REQ_LOAD, 16'h1A2B, 64'h3C4D_5E6F_7081_92A3, 16'h5678);
    send_request(ckt_pkg::REQ_CHECK, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF, '0);
    send_request(ckt_pkg::REQ_CHECK, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF, '0);
    send_request(ckt_pkg::REQ_CHECK, 16'h00A5, 64'h1122_3344_5566_7788, '0);
    send_request(ckt_pkg::REQ_CHECK, 16'h0000, 64'h0, '0);
    send_request(ckt_pkg::REQ_CHECK, 16'h1A2B, 64'h3C4D_5E6F_7081_92A3, '0);
    send_request(ckt_pkg::REQ_DELETE, '0, '0, 16'h0000);
    send_request(ckt_pkg::REQ_CHECK, 16'h1A2B, 64'h3C4D_5E6F_7081_92A3, '0);
    send_request(ckt_pkg::REQ_DELETE, '0, '0, 16'h1234);
    send_request(ckt_pkg::REQ_DELETE, '0, '0, 16'hBEEF);
    send_request(ckt_pkg::REQ_LOAD, 16'h5A5A, 64'hA5A5_A5A5_A5A5_A500, 16'h8000);
    send_request(ckt_pkg::REQ_CHECK, 16'h5A5A, 64'hA5A5_A5A5_A5A5_A500, '0);
    send_request(ckt_pkg::REQ_CLEAR, '0, '0, '0);
    send_request(ckt_pkg::REQ_CHECK, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF, '0);
    drain_responses();

    for (int p = 0; p < 4; p++) begin
      send_idle_pct = (p == 1) ? 77 : (p == 3) ? 13 : 0;
      stall_pct     = (p == 2) ? 77 : (p == 3) ? 13 : 0;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (n % 50 == 0) begin
          load_pct = (n == 0) ? 85 : (10 + 25 * $urandom_range(0, 3));
        end
        random_request();
      end
      drain_responses();
    end

    repeat (2 * CAP + 4) @(posedge clk_i);
    if (fail_cnt == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/ckt_pkg.sv
design/ckt_if.sv
design/ckt_cell.sv
design/ckt_ctrl.sv
design/card_key_table_with_presence_toggle_unit.sv
bench/ckt_checker.sv
bench/tb_top.sv
